FILE: hdl/lfgb_pkg.sv
// Package: shared types, constants and bit-search helpers for the largest-free-gap block
`timescale 1ns / 1ps
package lfgb_pkg;

	localparam int unsigned POS_W   = 16;
	localparam int unsigned ROW_W   = 10;
	localparam int unsigned BIT_W   = 6;
	localparam int unsigned SUM_W   = 4;
	localparam int unsigned NODE_W  = POS_W + 1;
	localparam int unsigned RIDX_W  = POS_W + 2;
	localparam int unsigned ROWS    = 1 << ROW_W;
	localparam int unsigned NODES   = 1 << NODE_W;
	localparam int unsigned SUMS    = 1 << SUM_W;

	localparam logic [POS_W-1:0]  MAX_POS   = '1;
	localparam logic              OP_PLACE  = 1'b0;
	localparam logic              OP_ASK    = 1'b1;
	localparam logic [RIDX_W-1:0] LEAF_BASE = RIDX_W'(1) << POS_W;

	typedef struct packed {
		logic             operation;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] block_size;
	} in_item_t;

	typedef struct packed {
		logic             fits;
		logic [POS_W-1:0] largest_gap;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic acc;
		logic eval;
		logic pscan;
		logic pfin;
		logic sscan;
		logic sfin;
		logic qinit;
		logic qstep;
		logic qacc;
		logic fin;
		logic tleaf;
		logic trd;
		logic tup;
		logic mark;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_ask;
		logic skip;
		logic pred_hit;
		logic succ_hit;
		logic succ_hit_q;
		logic p_hit;
		logic s_hit;
		logic at_top;
		logic second;
		logic q_more;
		logic q_odd;
		logic out_free;
	} status_t;

	function automatic logic [BIT_W-1:0] hi_bit(input logic [63:0] m);
		logic [63:0]      v;
		logic [BIT_W-1:0] r;
		v = m;
		r = '0;
		if (v[63:32] != '0) begin v = v >> 32; r[5] = 1'b1; end
		if (v[31:16] != '0) begin v = v >> 16; r[4] = 1'b1; end
		if (v[15:8] != '0) begin v = v >> 8; r[3] = 1'b1; end
		if (v[7:4] != '0) begin v = v >> 4; r[2] = 1'b1; end
		if (v[3:2] != '0) begin v = v >> 2; r[1] = 1'b1; end
		if (v[1]) begin r[0] = 1'b1; end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] lo_bit(input logic [63:0] m);
		logic [63:0]      v;
		logic [BIT_W-1:0] r;
		v = m;
		r = '0;
		if (v[31:0] == '0) begin v = v >> 32; r[5] = 1'b1; end
		if (v[15:0] == '0) begin v = v >> 16; r[4] = 1'b1; end
		if (v[7:0] == '0) begin v = v >> 8; r[3] = 1'b1; end
		if (v[3:0] == '0) begin v = v >> 4; r[2] = 1'b1; end
		if (v[1:0] == '0) begin v = v >> 2; r[1] = 1'b1; end
		if (!v[0]) begin r[0] = 1'b1; end
		return r;
	endfunction

	function automatic logic [63:0] mask_upto(input logic [BIT_W-1:0] b);
		return {64{1'b1}} >> (6'd63 - b);
	endfunction

	function automatic logic [63:0] mask_from(input logic [BIT_W-1:0] b);
		return {64{1'b1}} << b;
	endfunction

endpackage

FILE: hdl/lfgb_ctrl.sv
// Controller: sequencing state machine for clear, neighbor search, tree update and query
`timescale 1ns / 1ps
module lfgb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lfgb_pkg::status_t st,
	output lfgb_pkg::cmd_t    cmd
);

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_EVAL  = 15'b000000000000100,
		S_PSCAN = 15'b000000000001000,
		S_PFIN  = 15'b000000000010000,
		S_SSCAN = 15'b000000000100000,
		S_SFIN  = 15'b000000001000000,
		S_QINIT = 15'b000000010000000,
		S_QSTEP = 15'b000000100000000,
		S_QACC  = 15'b000001000000000,
		S_FIN   = 15'b000010000000000,
		S_TLEAF = 15'b000100000000000,
		S_TRD   = 15'b001000000000000,
		S_TUP   = 15'b010000000000000,
		S_MARK  = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (st.clr_last) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_EVAL;
			S_EVAL: begin
				if (st.is_ask) begin
					state_d = st.pred_hit ? S_QINIT : S_PSCAN;
				end else if (st.skip) begin
					state_d = S_IDLE;
				end else if (!st.pred_hit) begin
					state_d = S_PSCAN;
				end else begin
					state_d = st.succ_hit ? S_TLEAF : S_SSCAN;
				end
			end
			S_PSCAN: if (st.p_hit) state_d = S_PFIN;
			S_PFIN: begin
				if (st.is_ask) state_d = S_QINIT;
				else state_d = st.succ_hit_q ? S_TLEAF : S_SSCAN;
			end
			S_SSCAN: if (st.s_hit) state_d = S_SFIN;
			S_SFIN:  state_d = S_TLEAF;
			S_TLEAF: state_d = S_TRD;
			S_TRD:   state_d = S_TUP;
			S_TUP: begin
				if (st.at_top) state_d = st.second ? S_MARK : S_TLEAF;
				else state_d = S_TRD;
			end
			S_MARK:  state_d = S_IDLE;
			S_QINIT: state_d = S_QSTEP;
			S_QSTEP: begin
				if (!st.q_more) state_d = S_FIN;
				else if (st.q_odd) state_d = S_QACC;
			end
			S_QACC:  state_d = S_QSTEP;
			S_FIN:   if (st.out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.clear = (state_q == S_CLEAR);
	assign cmd.acc   = (state_q == S_IDLE) && in_valid;
	assign cmd.eval  = (state_q == S_EVAL);
	assign cmd.pscan = (state_q == S_PSCAN);
	assign cmd.pfin  = (state_q == S_PFIN);
	assign cmd.sscan = (state_q == S_SSCAN);
	assign cmd.sfin  = (state_q == S_SFIN);
	assign cmd.qinit = (state_q == S_QINIT);
	assign cmd.qstep = (state_q == S_QSTEP);
	assign cmd.qacc  = (state_q == S_QACC);
	assign cmd.fin   = (state_q == S_FIN);
	assign cmd.tleaf = (state_q == S_TLEAF);
	assign cmd.trd   = (state_q == S_TRD);
	assign cmd.tup   = (state_q == S_TUP);
	assign cmd.mark  = (state_q == S_MARK);

endmodule

FILE: hdl/lfgb_dpath.sv
// Datapath: obstacle bitmap, word summary, range-max tree memory and result register
`timescale 1ns / 1ps
module lfgb_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  lfgb_pkg::cmd_t      cmd,
	input  lfgb_pkg::in_item_t  in_data,
	input  logic                out_ready,
	output lfgb_pkg::status_t   st,
	output lfgb_pkg::out_item_t out_data,
	output logic                out_valid
);

	logic [63:0]                  map_mem [lfgb_pkg::ROWS];
	logic [lfgb_pkg::POS_W-1:0]   tree_mem [lfgb_pkg::NODES];
	logic [63:0]                  sum_q [lfgb_pkg::SUMS];

	logic [63:0]                  mrd_q, pw_q;
	logic [lfgb_pkg::POS_W-1:0]   trd_q;
	logic                         op_q;
	logic [lfgb_pkg::POS_W-1:0]   pos_q, need_q, left_q, right_q, val_q, best_q;
	logic [lfgb_pkg::SUM_W-1:0]   ps_q, ss_q;
	logic                         pf_q, sf_q, sh_q, setsel_q;
	logic [lfgb_pkg::ROW_W-1:0]   wwp_q, wws_q;
	logic [lfgb_pkg::NODE_W-1:0]  node_q, clr_q;
	logic [lfgb_pkg::RIDX_W-1:0]  l_q, r_q;
	lfgb_pkg::out_item_t          out_q;
	logic                         ovalid_q;

	logic [lfgb_pkg::ROW_W-1:0]   w, wp, wn, wwp, wws;
	logic [lfgb_pkg::BIT_W-1:0]   b;
	logic [63:0]                  up_m, dn_m, pm, sm;
	logic [lfgb_pkg::POS_W-1:0]   set_p, set_v, vmax, clr_v, part, fbest;
	logic [lfgb_pkg::NODE_W-1:0]  clr_nx;
	logic [lfgb_pkg::RIDX_W-1:0]  rm1;
	logic                         map_we, map_re, tree_we, tree_re;
	logic [lfgb_pkg::ROW_W-1:0]   map_waddr, map_raddr;
	logic [63:0]                  map_wdata;
	logic [lfgb_pkg::NODE_W-1:0]  tree_waddr, tree_raddr;
	logic [lfgb_pkg::POS_W-1:0]   tree_wdata;
	logic                         out_free;

	always_comb begin
		w      = pos_q[lfgb_pkg::POS_W-1:lfgb_pkg::BIT_W];
		b      = pos_q[lfgb_pkg::BIT_W-1:0];
		wp     = w - lfgb_pkg::ROW_W'(1);
		wn     = w + lfgb_pkg::ROW_W'(1);
		up_m   = mrd_q & lfgb_pkg::mask_upto(b);
		dn_m   = mrd_q & lfgb_pkg::mask_from(b);
		pm     = sum_q[ps_q] & (pf_q ? lfgb_pkg::mask_upto(wp[lfgb_pkg::BIT_W-1:0]) : '1);
		sm     = sum_q[ss_q] & (sf_q ? lfgb_pkg::mask_from(wn[lfgb_pkg::BIT_W-1:0]) : '1);
		wwp    = {ps_q, lfgb_pkg::hi_bit(pm)};
		wws    = {ss_q, lfgb_pkg::lo_bit(sm)};
		set_p  = setsel_q ? right_q : pos_q;
		set_v  = setsel_q ? (right_q - pos_q) : (pos_q - left_q);
		vmax   = (trd_q > val_q) ? trd_q : val_q;
		clr_nx = clr_q + lfgb_pkg::NODE_W'(1);
		clr_v  = ((clr_q & clr_nx) == '0 && clr_q != '0) ? lfgb_pkg::MAX_POS : '0;
		rm1    = r_q - lfgb_pkg::RIDX_W'(1);
		part   = pos_q - left_q;
		fbest  = (part > best_q) ? part : best_q;
		out_free = !ovalid_q || out_ready;
	end

	// memory port muxing
	always_comb begin
		map_we    = 1'b0;
		map_waddr = w;
		map_wdata = pw_q | (64'd1 << b);
		if (cmd.clear) begin
			map_we    = (clr_q[lfgb_pkg::NODE_W-1:lfgb_pkg::ROW_W] == '0);
			map_waddr = clr_q[lfgb_pkg::ROW_W-1:0];
			map_wdata = '0;
			if (clr_q[lfgb_pkg::ROW_W-1:0] == '0) map_wdata[0] = 1'b1;
			if (clr_q[lfgb_pkg::ROW_W-1:0] == '1) map_wdata[63] = 1'b1;
		end else if (cmd.mark) begin
			map_we = 1'b1;
		end
		map_re    = 1'b0;
		map_raddr = in_data.position[lfgb_pkg::POS_W-1:lfgb_pkg::BIT_W];
		if (cmd.acc) begin
			map_re = 1'b1;
		end else if (cmd.pscan) begin
			map_re    = (pm != '0);
			map_raddr = wwp;
		end else if (cmd.sscan) begin
			map_re    = (sm != '0);
			map_raddr = wws;
		end
		tree_we    = 1'b0;
		tree_waddr = clr_q;
		tree_wdata = clr_v;
		if (cmd.clear) begin
			tree_we = 1'b1;
		end else if (cmd.tleaf) begin
			tree_we    = 1'b1;
			tree_waddr = {1'b1, set_p};
			tree_wdata = set_v;
		end else if (cmd.tup) begin
			tree_we    = 1'b1;
			tree_waddr = node_q >> 1;
			tree_wdata = vmax;
		end
		tree_re    = 1'b0;
		tree_raddr = node_q ^ lfgb_pkg::NODE_W'(1);
		if (cmd.trd) begin
			tree_re = 1'b1;
		end else if (cmd.qstep) begin
			tree_re    = (l_q < r_q) && (r_q[0] || l_q[0]);
			// left bound only turns odd at the root
			tree_raddr = l_q[0] ? l_q[lfgb_pkg::NODE_W-1:0] : rm1[lfgb_pkg::NODE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) mrd_q <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
		if (tree_re) trd_q <= tree_mem[tree_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0] <= 64'd1;
			for (int i = 1; i < lfgb_pkg::SUMS - 1; i++) sum_q[i] <= '0;
			sum_q[lfgb_pkg::SUMS-1] <= {1'b1, 63'd0};
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_nx;
			if (cmd.mark) sum_q[w[lfgb_pkg::ROW_W-1:lfgb_pkg::BIT_W]][w[lfgb_pkg::BIT_W-1:0]] <= 1'b1;
			if (cmd.fin && out_free) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			op_q     <= in_data.operation;
			pos_q    <= in_data.position;
			need_q   <= in_data.block_size;
			setsel_q <= 1'b0;
		end
		if (cmd.eval) begin
			pw_q <= mrd_q;
			sh_q <= (dn_m != '0);
			if (up_m != '0) left_q <= {w, lfgb_pkg::hi_bit(up_m)};
			if (dn_m != '0) right_q <= {w, lfgb_pkg::lo_bit(dn_m)};
			ps_q <= wp[lfgb_pkg::ROW_W-1:lfgb_pkg::BIT_W];
			ss_q <= wn[lfgb_pkg::ROW_W-1:lfgb_pkg::BIT_W];
			pf_q <= 1'b1;
			sf_q <= 1'b1;
		end
		if (cmd.pscan) begin
			wwp_q <= wwp;
			if (pm == '0) begin
				ps_q <= ps_q - lfgb_pkg::SUM_W'(1);
				pf_q <= 1'b0;
			end
		end
		if (cmd.pfin) left_q <= {wwp_q, lfgb_pkg::hi_bit(mrd_q)};
		if (cmd.sscan) begin
			wws_q <= wws;
			if (sm == '0) begin
				ss_q <= ss_q + lfgb_pkg::SUM_W'(1);
				sf_q <= 1'b0;
			end
		end
		if (cmd.sfin) right_q <= {wws_q, lfgb_pkg::lo_bit(mrd_q)};
		if (cmd.tleaf) begin
			node_q <= {1'b1, set_p};
			val_q  <= set_v;
		end
		if (cmd.tup) begin
			node_q <= node_q >> 1;
			val_q  <= vmax;
			if (node_q[lfgb_pkg::NODE_W-1:1] == lfgb_pkg::POS_W'(1)) setsel_q <= 1'b1;
		end
		if (cmd.qinit) begin
			l_q    <= lfgb_pkg::LEAF_BASE;
			r_q    <= lfgb_pkg::RIDX_W'(left_q) + lfgb_pkg::LEAF_BASE + lfgb_pkg::RIDX_W'(1);
			best_q <= '0;
		end
		if (cmd.qstep) begin
			l_q <= (l_q + lfgb_pkg::RIDX_W'(l_q[0])) >> 1;
			r_q <= ((l_q < r_q) && r_q[0]) ? (rm1 >> 1) : (r_q >> 1);
		end
		if (cmd.qacc && trd_q > best_q) best_q <= trd_q;
		if (cmd.fin && out_free) begin
			out_q.fits        <= (fbest >= need_q);
			out_q.largest_gap <= fbest;
		end
	end

	assign st.clr_last   = (clr_q == '1);
	assign st.is_ask     = (op_q == lfgb_pkg::OP_ASK);
	assign st.skip       = (pos_q == '0) || (pos_q == lfgb_pkg::MAX_POS) || mrd_q[b];
	assign st.pred_hit   = (up_m != '0);
	assign st.succ_hit   = (dn_m != '0);
	assign st.succ_hit_q = sh_q;
	assign st.p_hit      = (pm != '0);
	assign st.s_hit      = (sm != '0);
	assign st.at_top     = (node_q[lfgb_pkg::NODE_W-1:1] == lfgb_pkg::POS_W'(1));
	assign st.second     = setsel_q;
	assign st.q_more     = (l_q < r_q);
	assign st.q_odd      = r_q[0] || l_q[0];
	assign st.out_free   = out_free;

	assign out_data  = out_q;
	assign out_valid = ovalid_q;

endmodule

FILE: hdl/largest_free_gap_before_point_core.sv
// Top level: largest free gap before a point, controller plus datapath
//
//  channel   dir  handshake               payload
//  in        in   in_valid / in_ready     in_data  (operation, position, block_size)
//  out       out  out_valid / out_ready   out_data (fits, largest_gap)
//
// After reset a clearing pass initializes the tree and bitmap; no input then.
// Place: eval, neighbor word scans (up to 16 words each side), two leaf-to-root tree updates.
// Ask: eval, left word scan if needed (up to 16 words), then a query over the tree memory port.
// One item at a time; a waiting result holds the next ask in its final step.
`timescale 1ns / 1ps
module largest_free_gap_before_point_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lfgb_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lfgb_pkg::out_item_t out_data
);

	lfgb_pkg::cmd_t    cmd;
	lfgb_pkg::status_t st;

	lfgb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	lfgb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_ready (out_ready),
		.st        (st),
		.out_data  (out_data),
		.out_valid (out_valid)
	);

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transfer while busy");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.fin))
		else $error("result appeared outside the finish step");

	a_no_ready_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !in_ready)
		else $error("input ready during clearing pass");

endmodule

FILE: test/tb.sv
// Testbench for the largest-free-gap core: directed and random place/ask traffic checked against a predictor
`timescale 1ns / 1ps
module tb;

	class gap_scoreboard;
		int                  obstacles[$];
		int                  gap_at[int];
		lfgb_pkg::out_item_t answers[$];
		int                  errors;
		int                  reported;
		int                  places;
		int                  asks;
		int                  checked;

		function new();
			obstacles = '{0, 65535};
			gap_at[0] = 0;
			gap_at[65535] = 65535;
		endfunction

		function void note_transfer(lfgb_pkg::in_item_t it);
			int                  p;
			int                  i;
			int                  last;
			int                  best;
			lfgb_pkg::out_item_t r;
			p = it.position;
			if (it.operation == lfgb_pkg::OP_PLACE) begin
				places++;
				if (p == 0 || p >= 65535 || gap_at.exists(p))
					return;
				i = 0;
				while (obstacles[i + 1] < p)
					i++;
				gap_at[p] = p - obstacles[i];
				gap_at[obstacles[i + 1]] = obstacles[i + 1] - p;
				obstacles.insert(i + 1, p);
			end else begin
				asks++;
				last = 0;
				best = 0;
				foreach (obstacles[k]) begin
					if (obstacles[k] <= p) begin
						last = obstacles[k];
						if (gap_at[last] > best)
							best = gap_at[last];
					end
				end
				if (p - last > best)
					best = p - last;
				r.fits = (best >= it.block_size);
				r.largest_gap = best[15:0];
				answers.insert(answers.size(), r);
			end
		endfunction

		function void check_result(lfgb_pkg::out_item_t got);
			lfgb_pkg::out_item_t want;
			checked++;
			if (answers.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result fits=%0d gap=%0d", got.fits, got.largest_gap);
				end
				return;
			end
			want = answers.pop_front();
			if (got.fits !== want.fits || got.largest_gap !== want.largest_gap) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: exp fits=%0d gap=%0d, got fits=%0d gap=%0d",
						want.fits, want.largest_gap, got.fits, got.largest_gap);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	lfgb_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	lfgb_pkg::out_item_t out_data;

	gap_scoreboard sb;
	int            sent;
	bit            hold_req;
	bit            hold_done;

	largest_free_gap_before_point_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	task automatic send(input logic op, input int pos, input int need);
		lfgb_pkg::in_item_t it;
		int                 g;
		it.operation = op;
		it.position = pos[15:0];
		it.block_size = need[15:0];
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_transfer(it);
		sent++;
		if (sent == 300)
			hold_req = 1'b1;
	endtask

	function automatic int near_obstacle();
		int o;
		o = sb.obstacles[$urandom_range(0, sb.obstacles.size() - 1)];
		o = o + $urandom_range(0, 16) - 8;
		if (o < 0)
			o = 0;
		if (o > 65535)
			o = 65535;
		return o;
	endfunction

	task automatic run_random(input int n);
		int r;
		int pos;
		int need;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					pos = $urandom_range(0, 65535);
				else if (r < 85)
					pos = sb.obstacles[$urandom_range(0, sb.obstacles.size() - 1)];
				else
					pos = near_obstacle();
				send(lfgb_pkg::OP_PLACE, pos, $urandom_range(0, 65535));
			end else begin
				pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : near_obstacle();
				r = $urandom_range(0, 99);
				if (r < 30)
					need = $urandom_range(0, 65535);
				else if (r < 65)
					need = $urandom_range(0, 8192);
				else
					need = $urandom_range(0, 600);
				send(lfgb_pkg::OP_ASK, pos, need);
			end
		end
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall = 3000;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
			if (idle >= 1000000) begin
				$display("watchdog expired");
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		sent = 0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send(lfgb_pkg::OP_ASK, 0, 0);
		send(lfgb_pkg::OP_ASK, 65535, 65535);
		send(lfgb_pkg::OP_ASK, 65535, 0);
		send(lfgb_pkg::OP_PLACE, 0, 0);
		send(lfgb_pkg::OP_PLACE, 65535, 65535);
		send(lfgb_pkg::OP_ASK, 32768, 32769);
		send(lfgb_pkg::OP_PLACE, 1, 0);
		send(lfgb_pkg::OP_PLACE, 1, 0);
		send(lfgb_pkg::OP_ASK, 1, 1);
		send(lfgb_pkg::OP_ASK, 1, 2);
		send(lfgb_pkg::OP_PLACE, 65534, 0);
		send(lfgb_pkg::OP_ASK, 65534, 65533);
		send(lfgb_pkg::OP_ASK, 65535, 65533);
		send(lfgb_pkg::OP_PLACE, 32768, 0);
		send(lfgb_pkg::OP_ASK, 32767, 32767);
		send(lfgb_pkg::OP_ASK, 32768, 32767);
		send(lfgb_pkg::OP_ASK, 65535, 32767);
		send(lfgb_pkg::OP_PLACE, 32768, 0);
		send(lfgb_pkg::OP_PLACE, 43690, 21845);
		send(lfgb_pkg::OP_ASK, 43690, 65535);
		send(lfgb_pkg::OP_ASK, 21845, 0);

		run_random(750);
		in_valid <= 1'b0;

		while (sb.answers.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		$display("run: %0d places, %0d asks, %0d results checked, %0d obstacles at end",
			sb.places, sb.asks, sb.checked, sb.obstacles.size());
		$display("mismatches: %0d", sb.errors);
		if (sb.errors == 0 && sb.answers.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

FILE: largest_free_gap_before_point_core.f
hdl/lfgb_pkg.sv
hdl/lfgb_ctrl.sv
hdl/lfgb_dpath.sv
hdl/largest_free_gap_before_point_core.sv
test/tb.sv
